@@ rtl/vtx_pkg.sv @@
// ----------------------------------------------------------------------------
// vtx_pkg
// Shared types and constants for the 4x4 vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtx_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int VAL_W         = 32;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 67;

  typedef enum logic [1:0] {
    OP_FULL   = 2'd0,
    OP_NORMAL = 2'd1,
    OP_POINT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] mx;
    logic signed [SUM_W-1:0] mn;
    mx = SUM_W'(signed'(32'sh7fffffff));
    mn = -SUM_W'(64'sh80000000);
    if (v > mx) sat32 = 32'sh7fffffff;
    else if (v < mn) sat32 = 32'sh80000000;
    else sat32 = v[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/vtx_mac.sv @@
// ----------------------------------------------------------------------------
// vtx_mac
// Three-stage transform: multiply, sum and shift, saturate.
// ----------------------------------------------------------------------------
module vtx_mac import vtx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  op_t                     in_op,
  input  logic signed [VAL_W-1:0] in_v [4],
  input  logic signed [VAL_W-1:0] m [4][4],
  output logic                    res_valid,
  output op_t                     res_op,
  output logic signed [VAL_W-1:0] res [4]
);

  logic                     v1;
  op_t                      op1;
  logic signed [PROD_W-1:0] prod [4][4];
  logic                     v2;
  op_t                      op2;
  logic signed [SUM_W-1:0]  sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= in_op;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i == 3 && in_op != OP_FULL)
          prod[i][j] <= (in_op == OP_POINT) ? (PROD_W'(m[i][j]) <<< FRAC_BITS) : '0;
        else
          prod[i][j] <= PROD_W'(m[i][j]) * PROD_W'(in_v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    op2 <= op1;
    for (int j = 0; j < 4; j++) begin
      sum[j] <= (SUM_W'(prod[0][j]) + SUM_W'(prod[1][j]) + SUM_W'(prod[2][j])
                + SUM_W'(prod[3][j])) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    res_op <= op2;
    for (int j = 0; j < 4; j++) begin
      res[j] <= sat32(sum[j]);
    end
  end

endmodule

@@ rtl/vtx_div.sv @@
// ----------------------------------------------------------------------------
// vtx_div
// Pipelined restoring divider: one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module vtx_div import vtx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  op_t                     in_op,
  input  logic signed [VAL_W-1:0] in_r [4],
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_r [4],
  output logic                    dz
);

  localparam int NB     = VAL_W + FRAC_BITS;
  localparam int STAGES = NB;

  logic                    sv   [STAGES+1];
  op_t                     sop  [STAGES+1];
  logic signed [VAL_W-1:0] sraw [STAGES+1][4];
  logic [VAL_W-1:0]        sden [STAGES+1];
  logic [NB-1:0]           snum [STAGES+1][3];
  logic [VAL_W:0]          srem [STAGES+1][3];
  logic [NB-1:0]           squo [STAGES+1][3];
  logic                    sneg [STAGES+1][3];

  always_comb begin
    sv[0]  = in_valid;
    sop[0] = in_op;
    sden[0] = in_r[3][VAL_W-1] ? VAL_W'(-in_r[3]) : VAL_W'(in_r[3]);
    for (int k = 0; k < 4; k++) sraw[0][k] = in_r[k];
    for (int k = 0; k < 3; k++) begin
      snum[0][k] = {(in_r[k][VAL_W-1] ? VAL_W'(-in_r[k]) : VAL_W'(in_r[k])),
                    {FRAC_BITS{1'b0}}};
      srem[0][k] = '0;
      squo[0][k] = '0;
      sneg[0][k] = in_r[k][VAL_W-1] ^ in_r[3][VAL_W-1];
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else     sv[s+1] <= sv[s];
    end
    always_ff @(posedge clk) begin
      logic [VAL_W+1:0] t;
      sop[s+1]  <= sop[s];
      sden[s+1] <= sden[s];
      sraw[s+1] <= sraw[s];
      sneg[s+1] <= sneg[s];
      for (int k = 0; k < 3; k++) begin
        t = {srem[s][k], snum[s][k][NB-1]};
        snum[s+1][k] <= snum[s][k] << 1;
        if (t >= {2'b00, sden[s]}) begin
          srem[s+1][k] <= (VAL_W+1)'(t - {2'b00, sden[s]});
          squo[s+1][k] <= {squo[s][k][NB-2:0], 1'b1};
        end else begin
          srem[s+1][k] <= t[VAL_W:0];
          squo[s+1][k] <= {squo[s][k][NB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] q;
    logic signed [VAL_W-1:0] r [4];
    logic                    z;
    if (rst) out_valid <= 1'b0;
    else     out_valid <= sv[STAGES];
    z = 1'b0;
    r[3] = (sop[STAGES] == OP_FULL) ? sraw[STAGES][3] : '0;
    for (int k = 0; k < 3; k++) begin
      q = sneg[STAGES][k] ? -SUM_W'(squo[STAGES][k]) : SUM_W'(squo[STAGES][k]);
      r[k] = '0;
      case (sop[STAGES])
        OP_FULL: r[k] = sraw[STAGES][k];
        OP_NORMAL: r[k] = sraw[STAGES][k];
        OP_POINT: begin
          if (sden[STAGES] == '0) begin
            z = 1'b1;
            if (sraw[STAGES][k] > 0) r[k] = 32'sh7fffffff;
            else if (sraw[STAGES][k] < 0) r[k] = 32'sh80000000;
          end else begin
            r[k] = sat32(q);
          end
        end
        default: r[k] = '0;
      endcase
    end
    out_r <= r;
    dz <= z;
  end

endmodule

@@ rtl/vertex_transform_4x4_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit
// The pipeline depth is set by the one-bit-per-stage divider.
// Throughput: one transaction per cycle.
// Reset clears the pipeline valids and loads the identity matrix.
// Results are shown for one cycle under done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit import vtx_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op,
  input  logic signed [VAL_W-1:0] in_x,
  input  logic signed [VAL_W-1:0] in_y,
  input  logic signed [VAL_W-1:0] in_z,
  input  logic signed [VAL_W-1:0] in_w,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  output logic                    done,
  output logic signed [VAL_W-1:0] out_x,
  output logic signed [VAL_W-1:0] out_y,
  output logic signed [VAL_W-1:0] out_z,
  output logic signed [VAL_W-1:0] out_w,
  output logic                    divide_by_zero
);

  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  logic [REG_W-1:0]        regs [NUM_REGS];
  logic signed [VAL_W-1:0] m [4][4];
  logic signed [VAL_W-1:0] v [4];
  logic                    mv;
  op_t                     mop;
  logic signed [VAL_W-1:0] mres [4];
  logic signed [VAL_W-1:0] dres [4];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      // load ONE on the diagonal, zero elsewhere
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= {(((i >> 1) == 2 * (i & 1) + 1) ? ONE : VAL_W'(0)),
                    (((i >> 1) == 2 * (i & 1)) ? ONE : VAL_W'(0))};
      end
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m[i][0] = regs[2*i][31:0];
      m[i][1] = regs[2*i][63:32];
      m[i][2] = regs[2*i+1][31:0];
      m[i][3] = regs[2*i+1][63:32];
    end
    v[0] = in_x;
    v[1] = in_y;
    v[2] = in_z;
    v[3] = in_w;
  end

  vtx_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .in_valid(start), .in_op(op_t'(op)), .in_v(v), .m(m),
    .res_valid(mv), .res_op(mop), .res(mres)
  );

  vtx_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .in_valid(mv), .in_op(mop), .in_r(mres),
    .out_valid(done), .out_r(dres), .dz(divide_by_zero)
  );

  assign out_x = dres[0];
  assign out_y = dres[1];
  assign out_z = dres[2];
  assign out_w = dres[3];

endmodule
